[design/mva_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mva_pkg
// Types, codes and sizes shared by the voice allocator and its voice cells.
// ----------------------------------------------------------------------------
package mva_pkg;

  localparam int MAX_VOICES_DEF = 16;
  localparam int CTRL_SLOTS_DEF = 8;

  localparam int NOTE_W  = 7;
  localparam int SLOT_W  = 4;
  localparam int POLY_W  = 5;
  localparam int VALUE_W = 14;
  localparam int CFG_W   = 64;
  localparam int CIDX_W  = 3;

  // MIDI message types (upper status nibble)
  localparam logic [3:0] MSG_NOTE_OFF      = 4'd8;
  localparam logic [3:0] MSG_NOTE_ON       = 4'd9;
  localparam logic [3:0] MSG_POLY_PRESSURE = 4'd10;
  localparam logic [3:0] MSG_CONTROL       = 4'd11;
  localparam logic [3:0] MSG_CHAN_PRESSURE = 4'd13;
  localparam logic [3:0] MSG_BEND          = 4'd14;

  // controller slot codes
  localparam logic [7:0] CODE_BEND          = 8'd128;
  localparam logic [7:0] CODE_CHAN_PRESSURE = 8'd129;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] REG_POLYPHONY      = 3'd0;
  localparam logic [CIDX_W-1:0] REG_POLYTOUCH_EN   = 3'd1;
  localparam logic [CIDX_W-1:0] REG_CHANNEL_MASK   = 3'd2;
  localparam logic [CIDX_W-1:0] REG_NOTE_MASK_LOW  = 3'd3;
  localparam logic [CIDX_W-1:0] REG_NOTE_MASK_HIGH = 3'd4;
  localparam logic [CIDX_W-1:0] REG_CTRL_MAP       = 3'd5;

  typedef enum logic [2:0] {
    KIND_IGNORED  = 3'd0,
    KIND_SET      = 3'd1,
    KIND_FREED    = 3'd2,
    KIND_PRESSURE = 3'd3,
    KIND_CTRL     = 3'd4,
    KIND_DROPPED  = 3'd5
  } kind_t;

  // what the item asks of the voice chain
  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_ON      = 3'd1,  // claim first free voice
    OP_ON_ZERO = 3'd2,  // note 0: voice 0, if polyphony enables it
    OP_OFF     = 3'd3,
    OP_TOUCH   = 3'd4
  } op_t;

  // item travelling down the voice chain, one cell per cycle
  typedef struct packed {
    logic              valid;
    op_t               op;
    logic [NOTE_W-1:0] key;
    logic [NOTE_W-1:0] data;
    logic              touch_en;
    logic              found;
    logic [SLOT_W-1:0] slot;
    logic [NOTE_W-1:0] note;
    logic [NOTE_W-1:0] velocity;
    logic [NOTE_W-1:0] pressure;
  } tok_t;

endpackage

[design/mva_voice_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mva_voice_cell
// One voice slot: holds note, velocity and pressure, matches the passing item.
// ----------------------------------------------------------------------------
module mva_voice_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [mva_pkg::POLY_W-1:0] poly,
  input  mva_pkg::tok_t              tok_i,
  output mva_pkg::tok_t              tok_o
);

  localparam logic [mva_pkg::SLOT_W-1:0] IDX = mva_pkg::SLOT_W'(CELL_IDX);

  logic [mva_pkg::NOTE_W-1:0] note_r, note_nxt;
  logic [mva_pkg::NOTE_W-1:0] vel_r, vel_nxt;
  logic [mva_pkg::NOTE_W-1:0] press_r, press_nxt;
  mva_pkg::tok_t              tok_r, tok_nxt;
  logic                       active;
  logic                       hit;

  // polyphony above the chain length saturates naturally
  assign active = poly > {1'b0, IDX};

  always_comb begin
    hit = 1'b0;
    if (tok_i.valid && !tok_i.found && active) begin
      unique case (tok_i.op)
        mva_pkg::OP_ON:      hit = (note_r == '0);
        mva_pkg::OP_ON_ZERO: hit = (CELL_IDX == 0);
        mva_pkg::OP_OFF:     hit = (note_r == tok_i.key);
        mva_pkg::OP_TOUCH:   hit = (note_r == tok_i.key);
        default:             hit = 1'b0;
      endcase
    end
  end

  always_comb begin
    note_nxt  = note_r;
    vel_nxt   = vel_r;
    press_nxt = press_r;
    tok_nxt   = tok_i;
    if (hit) begin
      unique case (tok_i.op)
        mva_pkg::OP_ON, mva_pkg::OP_ON_ZERO: begin
          note_nxt = tok_i.key;
          vel_nxt  = tok_i.data;
        end
        mva_pkg::OP_OFF: begin
          note_nxt = '0;
          vel_nxt  = '0;
          if (tok_i.touch_en) press_nxt = '0;
        end
        mva_pkg::OP_TOUCH: begin
          press_nxt = tok_i.data;
        end
        default: ;
      endcase
      tok_nxt.found    = 1'b1;
      tok_nxt.slot     = IDX;
      tok_nxt.note     = note_nxt;
      tok_nxt.velocity = vel_nxt;
      tok_nxt.pressure = press_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      note_r  <= '0;
      vel_r   <= '0;
      press_r <= '0;
      tok_r   <= '0;
    end else begin
      note_r  <= note_nxt;
      vel_r   <= vel_nxt;
      press_r <= press_nxt;
      tok_r   <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

[design/midi_voice_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_voice_allocator
// Polyphonic voice allocation for MIDI channel messages.
// ----------------------------------------------------------------------------
// Usage:
//   Input: present a three-byte channel message on in_status_byte,
//   in_data_first and in_data_second and raise start; the item is taken at a
//   clock edge with start high and busy low. busy stays high until the report.
//   Output: one update report per item, shown for one cycle with out_valid.
//   The receiver cannot stall; the report must be taken in that cycle.
//   The item walks the voice chain one voice cell per cycle, each cell
//   matching and updating its voice; the report is registered after the
//   last cell. No new item is taken while one is in the chain, but a new
//   item can be taken in the out_valid cycle.
//   Controller slots are matched in the accept cycle.
//   Configuration: cfg_we/cfg_index/cfg_wdata, to be written by the user
//   only while idle; the block itself does not enforce this.
//   Reset: synchronous, active low; all voices free, polyphony 0, masks and
//   controller map all ones.
// ----------------------------------------------------------------------------
module midi_voice_allocator #(
  parameter int MAX_VOICES = mva_pkg::MAX_VOICES_DEF,
  parameter int CTRL_SLOTS = mva_pkg::CTRL_SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [7:0]                  in_status_byte,
  input  logic [mva_pkg::NOTE_W-1:0]  in_data_first,
  input  logic [mva_pkg::NOTE_W-1:0]  in_data_second,
  output logic                        out_valid,
  output logic [2:0]                  out_update_kind,
  output logic [mva_pkg::SLOT_W-1:0]  out_voice_slot,
  output logic [mva_pkg::NOTE_W-1:0]  out_voice_note_out,
  output logic [mva_pkg::NOTE_W-1:0]  out_voice_velocity_out,
  output logic [mva_pkg::NOTE_W-1:0]  out_voice_pressure_out,
  output logic [7:0]                  out_slots_changed,
  output logic [mva_pkg::VALUE_W-1:0] out_slot_value,
  input  logic                        cfg_we,
  input  logic [mva_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [mva_pkg::CFG_W-1:0]   cfg_wdata
);

  // configuration
  logic [mva_pkg::POLY_W-1:0] poly_r;
  logic                       touch_en_r;
  logic [15:0]                chan_mask_r;
  logic [63:0]                note_mask_lo_r;
  logic [63:0]                note_mask_hi_r;
  logic [63:0]                ctrl_map_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r         <= '0;
      touch_en_r     <= 1'b0;
      chan_mask_r    <= '1;
      note_mask_lo_r <= '1;
      note_mask_hi_r <= '1;
      ctrl_map_r     <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mva_pkg::REG_POLYPHONY:      poly_r         <= cfg_wdata[mva_pkg::POLY_W-1:0];
        mva_pkg::REG_POLYTOUCH_EN:   touch_en_r     <= cfg_wdata[0];
        mva_pkg::REG_CHANNEL_MASK:   chan_mask_r    <= cfg_wdata[15:0];
        mva_pkg::REG_NOTE_MASK_LOW:  note_mask_lo_r <= cfg_wdata;
        mva_pkg::REG_NOTE_MASK_HIGH: note_mask_hi_r <= cfg_wdata;
        mva_pkg::REG_CTRL_MAP:       ctrl_map_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // message decode
  logic                        busy_r;
  logic                        accept;
  logic [3:0]                  msg_type;
  logic                        note_ok;
  logic                        pass;
  mva_pkg::op_t                op;
  mva_pkg::kind_t              pre_kind;
  logic [7:0]                  match_code;
  logic [mva_pkg::VALUE_W-1:0] value;
  logic [7:0]                  changed;

  assign accept   = start && !busy_r;
  assign msg_type = in_status_byte[7:4];
  assign note_ok  = in_data_first[6] ? note_mask_hi_r[in_data_first[5:0]]
                                     : note_mask_lo_r[in_data_first[5:0]];

  always_comb begin
    pass       = chan_mask_r[in_status_byte[3:0]];
    op         = mva_pkg::OP_NONE;
    pre_kind   = mva_pkg::KIND_IGNORED;
    match_code = '1;
    value      = '0;
    if ((msg_type == mva_pkg::MSG_NOTE_ON || msg_type == mva_pkg::MSG_NOTE_OFF) && !note_ok)
      pass = 1'b0;
    if (pass) begin
      unique case (msg_type)
        mva_pkg::MSG_NOTE_ON:
          op = (in_data_first == '0) ? mva_pkg::OP_ON_ZERO : mva_pkg::OP_ON;
        mva_pkg::MSG_NOTE_OFF:
          op = mva_pkg::OP_OFF;
        mva_pkg::MSG_POLY_PRESSURE:
          op = touch_en_r ? mva_pkg::OP_TOUCH : mva_pkg::OP_NONE;
        mva_pkg::MSG_CONTROL: begin
          pre_kind   = mva_pkg::KIND_CTRL;
          match_code = {1'b0, in_data_first};
          value      = mva_pkg::VALUE_W'(in_data_second);
        end
        mva_pkg::MSG_BEND: begin
          pre_kind   = mva_pkg::KIND_CTRL;
          match_code = mva_pkg::CODE_BEND;
          value      = {in_data_second, in_data_first};
        end
        mva_pkg::MSG_CHAN_PRESSURE: begin
          pre_kind   = mva_pkg::KIND_CTRL;
          match_code = mva_pkg::CODE_CHAN_PRESSURE;
          value      = mva_pkg::VALUE_W'(in_data_first);
        end
        default: ;
      endcase
    end
  end

  // slot codes 130..255 never equal a match code from a controller message
  always_comb begin
    changed = '0;
    for (int i = 0; i < CTRL_SLOTS; i++) begin
      if (pre_kind == mva_pkg::KIND_CTRL && ctrl_map_r[8*i +: 8] == match_code)
        changed[i] = 1'b1;
    end
  end

  // item held at the chain head, plus what bypasses the chain
  mva_pkg::tok_t               inj_r, inj_nxt;
  mva_pkg::kind_t              pre_kind_r;
  logic [7:0]                  changed_r;
  logic [mva_pkg::VALUE_W-1:0] value_r;
  mva_pkg::tok_t               tok [MAX_VOICES+1];

  always_comb begin
    inj_nxt          = '0;
    inj_nxt.valid    = accept;
    inj_nxt.op       = op;
    inj_nxt.key      = in_data_first;
    inj_nxt.data     = in_data_second;
    inj_nxt.touch_en = touch_en_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inj_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      inj_r <= inj_nxt;
      if (accept)
        busy_r <= 1'b1;
      else if (tok[MAX_VOICES].valid)
        busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pre_kind_r <= pre_kind;
      changed_r  <= changed;
      value_r    <= value;
    end
  end

  assign tok[0] = inj_r;

  for (genvar g = 0; g < MAX_VOICES; g++) begin : g_voice
    mva_voice_cell #(
      .CELL_IDX(g)
    ) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .poly (poly_r),
      .tok_i(tok[g]),
      .tok_o(tok[g+1])
    );
  end

  // report
  mva_pkg::tok_t               tail;
  logic                        out_valid_r;
  mva_pkg::kind_t              kind_r, kind_nxt;
  logic [mva_pkg::SLOT_W-1:0]  slot_r, slot_nxt;
  logic [mva_pkg::NOTE_W-1:0]  note_r, note_nxt;
  logic [mva_pkg::NOTE_W-1:0]  vel_r, vel_nxt;
  logic [mva_pkg::NOTE_W-1:0]  press_r, press_nxt;
  logic [7:0]                  chg_r, chg_nxt;
  logic [mva_pkg::VALUE_W-1:0] val_r, val_nxt;

  assign tail = tok[MAX_VOICES];

  always_comb begin
    kind_nxt  = mva_pkg::KIND_IGNORED;
    slot_nxt  = '0;
    note_nxt  = '0;
    vel_nxt   = '0;
    press_nxt = '0;
    chg_nxt   = '0;
    val_nxt   = '0;
    if (tail.op == mva_pkg::OP_NONE) begin
      kind_nxt = pre_kind_r;
      if (pre_kind_r == mva_pkg::KIND_CTRL) begin
        chg_nxt = changed_r;
        val_nxt = value_r;
      end
    end else if (tail.found) begin
      unique case (tail.op)
        mva_pkg::OP_OFF:   kind_nxt = mva_pkg::KIND_FREED;
        mva_pkg::OP_TOUCH: kind_nxt = mva_pkg::KIND_PRESSURE;
        default:           kind_nxt = mva_pkg::KIND_SET;
      endcase
      slot_nxt  = tail.slot;
      note_nxt  = tail.note;
      vel_nxt   = tail.velocity;
      press_nxt = tail.pressure;
    end else if (tail.op == mva_pkg::OP_ON || tail.op == mva_pkg::OP_ON_ZERO) begin
      kind_nxt = mva_pkg::KIND_DROPPED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= tail.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tail.valid) begin
      kind_r  <= kind_nxt;
      slot_r  <= slot_nxt;
      note_r  <= note_nxt;
      vel_r   <= vel_nxt;
      press_r <= press_nxt;
      chg_r   <= chg_nxt;
      val_r   <= val_nxt;
    end
  end

  assign busy                   = busy_r;
  assign out_valid              = out_valid_r;
  assign out_update_kind        = kind_r;
  assign out_voice_slot         = slot_r;
  assign out_voice_note_out     = note_r;
  assign out_voice_velocity_out = vel_r;
  assign out_voice_pressure_out = press_r;
  assign out_slots_changed      = chg_r;
  assign out_slot_value         = val_r;

endmodule
